FILE: rtl/bucket_histogram_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bucket histogram engine
// Same-cycle and next-cycle implication checks on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BUCKET_HISTOGRAM_ENGINE_ASSERT_SVH
`define BUCKET_HISTOGRAM_ENGINE_ASSERT_SVH

`define BHE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BHE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bhe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_pkg
// Types and constants shared by the bucket histogram engine modules.
// ----------------------------------------------------------------------------
package bhe_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 64;
    localparam int OUT_CNT_W  = 32;
    localparam int IDX_W      = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    localparam logic [REG_IDX_W-1:0] REG_BOUNDS_IN_USE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_FIRST   = 3'd1;

    typedef enum logic [1:0] {
        CMD_OBSERVE = 2'd0,
        CMD_COLLECT = 2'd1,
        CMD_CLEAR   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        JOB_OBSERVE,
        JOB_COLLECT,
        JOB_CLEAR
    } t_job_op;

    typedef enum logic [1:0] {
        BK_EXEC,
        BK_LINES,
        BK_CLOSE
    } t_back_state;

    typedef struct packed {
        logic [1:0]          command;
        logic [SAMPLE_W-1:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic                 line_kind;
        logic [IDX_W-1:0]     bucket_index;
        logic [OUT_CNT_W-1:0] cumulative_count;
        logic [SUM_W-1:0]     total_sum;
        logic [OUT_CNT_W-1:0] total_count;
        logic                 last;
    } t_out_beat;

    typedef struct packed {
        t_job_op             op;
        logic [IDX_W-1:0]    bucket;
        logic [SAMPLE_W-1:0] sample;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: rtl/bucket_histogram_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucket_histogram_engine
// Cumulative bucket histogram with saturating counters. Commands are observe,
// collect and clear. Observe and clear run at one beat per cycle sustained
// while the queue is not full: the front stage registers the bucket found by
// comparing the sample with all bounds at once, a four-entry queue decouples
// it from the back stage, and the back stage updates one bucket counter, the
// 64-bit sum and the sample count together. Collect holds the back stage for
// n+2 output beats (n = bounds in use, capped at MAX_BOUNDS), one per cycle
// while the output is not stalled; the queue keeps taking beats until it
// fills. Bounds are written over APB at byte address 4*(i+1) for bound i;
// write them only while idle.
// ----------------------------------------------------------------------------
`include "bucket_histogram_engine_assert.svh"

module bucket_histogram_engine #(
    parameter int MAX_BOUNDS  = 7,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  bhe_pkg::t_in_beat              i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output bhe_pkg::t_out_beat             o_out_data,
    input  logic                           i_out_stall,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bhe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bhe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bhe_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [bhe_pkg::IDX_W-1:0]    w_n_eff;
    logic [bhe_pkg::SAMPLE_W-1:0] w_bounds [MAX_BOUNDS];
    logic                         w_push;
    bhe_pkg::t_job                w_push_job;
    logic                         w_pop;
    bhe_pkg::t_job                w_head;
    bhe_pkg::t_q_status           w_q_status;

    bhe_cfg #(
        .MAX_BOUNDS (MAX_BOUNDS)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_n_eff  (w_n_eff),
        .o_bounds (w_bounds)
    );

    bhe_front #(
        .MAX_BOUNDS (MAX_BOUNDS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_n_eff    (w_n_eff),
        .i_bounds   (w_bounds),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    bhe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    bhe_back #(
        .MAX_BOUNDS  (MAX_BOUNDS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n_eff     (w_n_eff),
        .i_head      (w_head),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    `BHE_ASSERT_SAME(a_close_fields, o_out_valid && o_out_data.last, o_out_data.line_kind && (o_out_data.bucket_index == 3'd0) && (o_out_data.cumulative_count == 32'd0), "closing beat carries bucket fields")
    `BHE_ASSERT_SAME(a_line_index, o_out_valid && !o_out_data.line_kind, o_out_data.bucket_index <= 3'(MAX_BOUNDS), "bucket beat index beyond bound limit")
    `BHE_ASSERT_SAME(a_no_push_full, w_push, !w_q_status.full, "job pushed into full queue")
    `BHE_ASSERT_SAME(a_no_pop_empty, w_pop, !w_q_status.empty, "job popped from empty queue")

endmodule

FILE: rtl/bhe_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_cfg
// APB register file: bound count and bucket upper bounds.
// ----------------------------------------------------------------------------
module bhe_cfg #(
    parameter int MAX_BOUNDS = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bhe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bhe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bhe_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [bhe_pkg::IDX_W-1:0]      o_n_eff,
    output logic [bhe_pkg::SAMPLE_W-1:0]   o_bounds [MAX_BOUNDS]
);

    logic [bhe_pkg::IDX_W-1:0]      r_biu;
    logic [bhe_pkg::SAMPLE_W-1:0]   r_bound [MAX_BOUNDS];
    logic                           w_wr;
    logic [bhe_pkg::REG_IDX_W-1:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[bhe_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= '0;
            for (int i = 0; i < MAX_BOUNDS; i++) begin
                r_bound[i] <= '0;
            end
        end else if (w_wr) begin
            if (w_idx == bhe_pkg::REG_BOUNDS_IN_USE) begin
                r_biu <= pwdata[bhe_pkg::IDX_W-1:0];
            end
            for (int i = 0; i < MAX_BOUNDS; i++) begin
                if (w_idx == bhe_pkg::REG_BOUND_FIRST + bhe_pkg::REG_IDX_W'(i)) begin
                    r_bound[i] <= pwdata[bhe_pkg::SAMPLE_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == bhe_pkg::REG_BOUNDS_IN_USE) begin
            prdata = bhe_pkg::APB_DATA_W'(r_biu);
        end
        for (int i = 0; i < MAX_BOUNDS; i++) begin
            if (w_idx == bhe_pkg::REG_BOUND_FIRST + bhe_pkg::REG_IDX_W'(i)) begin
                prdata = r_bound[i];
            end
        end
    end

    assign o_n_eff  = (r_biu > bhe_pkg::IDX_W'(MAX_BOUNDS)) ? bhe_pkg::IDX_W'(MAX_BOUNDS) : r_biu;
    assign o_bounds = r_bound;

endmodule

FILE: rtl/bhe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_front
// Input stage: accept commands, find the bucket of each sample, queue jobs.
// ----------------------------------------------------------------------------
module bhe_front #(
    parameter int MAX_BOUNDS = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  bhe_pkg::t_in_beat            i_in_data,
    output logic                         o_in_stall,
    input  logic [bhe_pkg::IDX_W-1:0]    i_n_eff,
    input  logic [bhe_pkg::SAMPLE_W-1:0] i_bounds [MAX_BOUNDS],
    input  bhe_pkg::t_q_status           i_q_status,
    output logic                         o_push,
    output bhe_pkg::t_job                o_job
);

    logic                       r_valid;
    bhe_pkg::t_job              r_job;
    logic                       n_valid;
    bhe_pkg::t_job              n_job;
    logic                       w_accept;
    logic [MAX_BOUNDS-1:0]      w_hit;
    logic [bhe_pkg::IDX_W-1:0]  w_bucket;

    assign o_in_stall = r_valid && i_q_status.full;
    assign o_push     = r_valid && !i_q_status.full;
    assign o_job      = r_job;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        for (int i = 0; i < MAX_BOUNDS; i++) begin
            w_hit[i] = (bhe_pkg::IDX_W'(i) < i_n_eff) && (i_in_data.sample <= i_bounds[i]);
        end
        w_bucket = i_n_eff;
        for (int i = MAX_BOUNDS - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_bucket = bhe_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_valid = r_valid && !o_push;
        n_job   = r_job;
        if (w_accept) begin
            n_job.bucket = w_bucket;
            n_job.sample = i_in_data.sample;
            unique case (i_in_data.command)
                bhe_pkg::CMD_OBSERVE: begin
                    n_valid  = 1'b1;
                    n_job.op = bhe_pkg::JOB_OBSERVE;
                end
                bhe_pkg::CMD_COLLECT: begin
                    n_valid  = 1'b1;
                    n_job.op = bhe_pkg::JOB_COLLECT;
                end
                bhe_pkg::CMD_CLEAR: begin
                    n_valid  = 1'b1;
                    n_job.op = bhe_pkg::JOB_CLEAR;
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

endmodule

FILE: rtl/bhe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_queue
// Short job queue between the front and back stages.
// ----------------------------------------------------------------------------
module bhe_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bhe_pkg::t_job      i_job,
    input  logic               i_pop,
    output bhe_pkg::t_job      o_head,
    output bhe_pkg::t_q_status o_status
);

    bhe_pkg::t_job                  r_mem [bhe_pkg::Q_DEPTH];
    logic [bhe_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [bhe_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [bhe_pkg::Q_PTR_W:0]      r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (bhe_pkg::Q_PTR_W + 1)'(bhe_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/bhe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_back
// Execution stage: bucket counters, sum and count, collect readout sequencer.
// ----------------------------------------------------------------------------
module bhe_back #(
    parameter int MAX_BOUNDS  = 7,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [bhe_pkg::IDX_W-1:0] i_n_eff,
    input  bhe_pkg::t_job             i_head,
    input  bhe_pkg::t_q_status        i_q_status,
    output logic                      o_pop,
    output logic                      o_out_valid,
    output bhe_pkg::t_out_beat        o_out_data,
    input  logic                      i_out_stall
);

    localparam int NUM_BUCKETS = MAX_BOUNDS + 1;
    localparam int BIDX_W      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    logic [COUNT_WIDTH-1:0]        r_counts [NUM_BUCKETS];
    logic [bhe_pkg::SUM_W-1:0]     r_sum;
    logic [COUNT_WIDTH-1:0]        r_count;
    bhe_pkg::t_back_state          r_state;
    bhe_pkg::t_back_state          n_state;
    logic [bhe_pkg::IDX_W-1:0]     r_idx;
    logic [bhe_pkg::IDX_W-1:0]     n_idx;
    logic [COUNT_WIDTH-1:0]        r_cum;
    logic [COUNT_WIDTH-1:0]        n_cum;
    logic                          r_out_valid;
    logic                          n_out_valid;
    bhe_pkg::t_out_beat            r_out_data;
    bhe_pkg::t_out_beat            n_out_data;
    logic                          w_out_free;
    logic                          w_do_obs;
    logic                          w_do_clr;
    logic [COUNT_WIDTH:0]          w_cum_add;
    logic [COUNT_WIDTH-1:0]        w_cum_sat;
    logic [bhe_pkg::SUM_W:0]       w_sum_add;
    logic [BIDX_W-1:0]             w_obs_idx;

    function automatic logic [bhe_pkg::OUT_CNT_W-1:0] clip_out(logic [COUNT_WIDTH-1:0] v);
        logic [63:0] ext;
        ext = 64'(v);
        return (|ext[63:bhe_pkg::OUT_CNT_W]) ? '1 : ext[bhe_pkg::OUT_CNT_W-1:0];
    endfunction

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_obs_idx  = i_head.bucket[BIDX_W-1:0];
    assign w_cum_add  = {1'b0, r_cum} + {1'b0, r_counts[r_idx[BIDX_W-1:0]]};
    assign w_cum_sat  = w_cum_add[COUNT_WIDTH] ? '1 : w_cum_add[COUNT_WIDTH-1:0];
    assign w_sum_add  = {1'b0, r_sum} + (bhe_pkg::SUM_W + 1)'(i_head.sample);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cum       = r_cum;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        w_do_obs    = 1'b0;
        w_do_clr    = 1'b0;
        if (w_out_free) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            bhe_pkg::BK_EXEC: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    case (i_head.op)
                        bhe_pkg::JOB_OBSERVE: w_do_obs = 1'b1;
                        bhe_pkg::JOB_CLEAR:   w_do_clr = 1'b1;
                        bhe_pkg::JOB_COLLECT: begin
                            n_state = bhe_pkg::BK_LINES;
                            n_idx   = '0;
                            n_cum   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            bhe_pkg::BK_LINES: begin
                if (w_out_free) begin
                    n_out_valid                 = 1'b1;
                    n_out_data.line_kind        = 1'b0;
                    n_out_data.bucket_index     = r_idx;
                    n_out_data.cumulative_count = clip_out(w_cum_sat);
                    n_out_data.total_sum        = '0;
                    n_out_data.total_count      = '0;
                    n_out_data.last             = 1'b0;
                    n_cum                       = w_cum_sat;
                    n_idx                       = r_idx + 1'b1;
                    if (r_idx == i_n_eff) begin
                        n_state = bhe_pkg::BK_CLOSE;
                    end
                end
            end
            bhe_pkg::BK_CLOSE: begin
                if (w_out_free) begin
                    n_out_valid                 = 1'b1;
                    n_out_data.line_kind        = 1'b1;
                    n_out_data.bucket_index     = '0;
                    n_out_data.cumulative_count = '0;
                    n_out_data.total_sum        = r_sum;
                    n_out_data.total_count      = clip_out(r_count);
                    n_out_data.last             = 1'b1;
                    n_state                     = bhe_pkg::BK_EXEC;
                end
            end
            default: n_state = bhe_pkg::BK_EXEC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bhe_pkg::BK_EXEC;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_count     <= '0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_counts[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_do_clr) begin
                r_sum   <= '0;
                r_count <= '0;
                for (int i = 0; i < NUM_BUCKETS; i++) begin
                    r_counts[i] <= '0;
                end
            end else if (w_do_obs) begin
                r_sum <= w_sum_add[bhe_pkg::SUM_W] ? '1 : w_sum_add[bhe_pkg::SUM_W-1:0];
                if (r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
                if (r_counts[w_obs_idx] != '1) begin
                    r_counts[w_obs_idx] <= r_counts[w_obs_idx] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cum      <= n_cum;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: tb/bhe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_checker
// Watches the command, result and APB channels of the bucket histogram engine.
// Shadow bounds follow the APB writes; shadow bucket counters, sum and sample
// count are updated for every accepted command beat. The result lines that a
// collect must produce are queued and compared field by field, in order, with
// every accepted result beat. The failure count, the number of lines still
// awaited and the number of lines compared go to the testbench top.
// ----------------------------------------------------------------------------
module bhe_checker
    import bhe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_beat              i_in_data,
    input  logic                  i_in_stall,
    input  logic                  i_out_valid,
    input  t_out_beat             i_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_lines_checked
);

    localparam int MAX_BOUNDS  = 7;
    localparam int NUM_BUCKETS = 8;
    localparam logic KIND_BUCKET = 1'b0;
    localparam logic KIND_CLOSE  = 1'b1;
    localparam logic [OUT_CNT_W-1:0] COUNT_MAX = '1;
    localparam int REPORT_LIMIT = 10;

    logic [IDX_W-1:0]     bounds_in_use;
    logic [SAMPLE_W-1:0]  bounds [MAX_BOUNDS];
    logic [OUT_CNT_W-1:0] shadow_counts [NUM_BUCKETS];
    logic [SUM_W-1:0]     sample_sum;
    logic [OUT_CNT_W-1:0] sample_count;
    t_out_beat            expected_lines [$];

    function automatic logic [OUT_CNT_W-1:0] sat_add(input logic [OUT_CNT_W-1:0] a,
                                                     input logic [OUT_CNT_W-1:0] b);
        logic [OUT_CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OUT_CNT_W] ? COUNT_MAX : s[OUT_CNT_W-1:0];
    endfunction

    task automatic histogram_step(input t_in_beat beat);
        int unsigned top_bucket;
        int unsigned k;
        logic [OUT_CNT_W-1:0] running;
        logic [SUM_W:0] wide_sum;
        t_out_beat line;
        top_bucket = (bounds_in_use > MAX_BOUNDS) ? MAX_BOUNDS : bounds_in_use;
        case (beat.command)
            CMD_OBSERVE: begin
                k = 0;
                while (k < top_bucket && beat.sample > bounds[k]) k++;
                shadow_counts[k] = sat_add(shadow_counts[k], 1);
                wide_sum = {1'b0, sample_sum} + {{(SUM_W-SAMPLE_W+1){1'b0}}, beat.sample};
                sample_sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
                sample_count = sat_add(sample_count, 1);
            end
            CMD_COLLECT: begin
                running = '0;
                for (k = 0; k <= top_bucket; k++) begin
                    running = sat_add(running, shadow_counts[k]);
                    line = '0;
                    line.line_kind = KIND_BUCKET;
                    line.bucket_index = IDX_W'(k);
                    line.cumulative_count = running;
                    expected_lines.insert(expected_lines.size(), line);
                end
                line = '0;
                line.line_kind = KIND_CLOSE;
                line.total_sum = sample_sum;
                line.total_count = sample_count;
                line.last = 1'b1;
                expected_lines.insert(expected_lines.size(), line);
            end
            CMD_CLEAR: begin
                for (k = 0; k < NUM_BUCKETS; k++) shadow_counts[k] = '0;
                sample_sum = '0;
                sample_count = '0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_beat want;
        t_out_beat got;
        if (!i_rst_n) begin
            bounds_in_use = '0;
            for (int k = 0; k < MAX_BOUNDS; k++) bounds[k] = '0;
            for (int k = 0; k < NUM_BUCKETS; k++) shadow_counts[k] = '0;
            sample_sum = '0;
            sample_count = '0;
            expected_lines.delete();
            o_fail_count = 0;
            o_lines_checked = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[APB_ADDR_W-1:2] == REG_BOUNDS_IN_USE)
                    bounds_in_use = i_pwdata[IDX_W-1:0];
                else
                    bounds[i_paddr[APB_ADDR_W-1:2] - REG_BOUND_FIRST] = i_pwdata;
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                o_lines_checked++;
                if (expected_lines.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected line kind=%0d idx=%0d cum=%0d %s%0d %s%0d last=%0d",
                                 $realtime, got.line_kind, got.bucket_index,
                                 got.cumulative_count, "sum=", got.total_sum,
                                 "cnt=", got.total_count, got.last);
                end else begin
                    want = expected_lines.pop_front();
                    if (got.line_kind !== want.line_kind
                        || got.bucket_index !== want.bucket_index
                        || got.cumulative_count !== want.cumulative_count
                        || got.total_sum !== want.total_sum
                        || got.total_count !== want.total_count
                        || got.last !== want.last) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT) begin
                            $display("%0t: line mismatch", $realtime);
                            $display("  expected kind=%0d idx=%0d cum=%0d sum=%0d cnt=%0d last=%0d",
                                     want.line_kind, want.bucket_index, want.cumulative_count,
                                     want.total_sum, want.total_count, want.last);
                            $display("  actual   kind=%0d idx=%0d cum=%0d sum=%0d cnt=%0d last=%0d",
                                     got.line_kind, got.bucket_index, got.cumulative_count,
                                     got.total_sum, got.total_count, got.last);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) histogram_step(i_in_data);
        end
        o_pending = expected_lines.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bucket histogram engine. A directed opening
// runs empty and extreme samples, the unused command, clear and collect with
// no bounds and with bounds at the ends of the range. Six random phases
// follow, each with new bounds (sorted wide, sorted narrow with ties, none,
// unsorted) written over APB while the engine is idle and without clearing
// the counts. Samples cluster on and next to the bounds. Both channels idle
// at random, with stretches of back-to-back beats. Checking is done by
// bhe_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import bhe_pkg::*;

    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int unsigned CYCLE_LIMIT    = 400_000;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          NUM_PHASES     = 6;
    localparam int          BEATS_PER_PHASE = 27;
    localparam int          NUM_BOUNDS     = 7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_beat              in_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_beat             out_data;
    logic                  out_stall = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          fail_count;
    int          pending;
    int          lines_checked;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    int          beats_sent = 0;
    int          collects_sent = 0;
    int          settings_used = 0;

    logic [IDX_W-1:0]    cfg_n;
    logic [SAMPLE_W-1:0] cfg_bounds [NUM_BOUNDS];

    bucket_histogram_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    bhe_checker u_histogram_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_data       (in_data),
        .i_in_stall      (in_stall),
        .i_out_valid     (out_valid),
        .i_out_data      (out_data),
        .i_out_stall     (out_stall),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_lines_checked (lines_checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // hold the result channel for a random number of cycles after each beat
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else if (out_valid && !out_stall) begin
            stall_left = rx_burst ? 0 : $urandom_range(0, 7);
            out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_bounds();
        write_reg(REG_BOUNDS_IN_USE, APB_DATA_W'(cfg_n));
        for (int k = 0; k < NUM_BOUNDS; k++)
            write_reg(REG_BOUND_FIRST + REG_IDX_W'(k), cfg_bounds[k]);
        settings_used++;
    endtask

    task automatic configure(input int mode);
        int unsigned span;
        logic [SAMPLE_W:0] acc;
        case (mode)
            0:       cfg_n = 3'd7;
            1:       cfg_n = 3'd3;
            2:       cfg_n = 3'd0;
            3:       cfg_n = 3'd5;
            4:       cfg_n = 3'd7;
            default: cfg_n = IDX_W'($urandom_range(1, 6));
        endcase
        span = (mode == 1) ? 20 : (mode == 4) ? 3 : 32'h2000_0000;
        cfg_bounds[0] = (span <= 20) ? $urandom_range(0, 40) : $urandom_range(0, 32'h0800_0000);
        for (int k = 1; k < NUM_BOUNDS; k++) begin
            acc = {1'b0, cfg_bounds[k-1]} + (SAMPLE_W+1)'($urandom_range(0, span));
            cfg_bounds[k] = acc[SAMPLE_W] ? '1 : acc[SAMPLE_W-1:0];
        end
        if (mode == 3)
            for (int k = 0; k < NUM_BOUNDS; k++) cfg_bounds[k] = $urandom();
        program_bounds();
    endtask

    task automatic send_beat(input logic [1:0] cmd, input logic [SAMPLE_W-1:0] value);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{command: cmd, sample: value};
        do @(posedge clk); while (in_stall);
        beats_sent++;
        if (cmd == CMD_COLLECT) collects_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] near_sample();
        int unsigned pick;
        logic [SAMPLE_W-1:0] base;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick <= 5) begin
            base = cfg_bounds[$urandom_range(0, NUM_BOUNDS - 1)];
            return base + SAMPLE_W'($urandom_range(0, 2)) - SAMPLE_W'(1);
        end
        return $urandom();
    endfunction

    task automatic random_beat();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 78)      send_beat(CMD_OBSERVE, near_sample());
        else if (r < 90) send_beat(CMD_COLLECT, $urandom());
        else if (r < 95) send_beat(CMD_CLEAR, $urandom());
        else             send_beat(CMD_UNUSED, $urandom());
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // no bounds in use: everything lands in the overflow bucket
        send_beat(CMD_COLLECT, '0);
        send_beat(CMD_OBSERVE, '0);
        send_beat(CMD_OBSERVE, '1);
        send_beat(CMD_UNUSED, 32'h1234_5678);
        send_beat(CMD_COLLECT, '1);
        send_beat(CMD_CLEAR, 32'h8000_0000);
        send_beat(CMD_COLLECT, '0);
        drain();

        // all bounds in use, spread over the ends of the range
        cfg_n = 3'd7;
        cfg_bounds = '{32'd0, 32'd1, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'hFFFF_FFFE, 32'hFFFF_FFFF};
        program_bounds();
        send_beat(CMD_OBSERVE, 32'd0);
        send_beat(CMD_OBSERVE, 32'd1);
        send_beat(CMD_OBSERVE, 32'd2);
        send_beat(CMD_OBSERVE, 32'd100);
        send_beat(CMD_OBSERVE, 32'd101);
        send_beat(CMD_OBSERVE, 32'h7FFF_FFFF);
        send_beat(CMD_OBSERVE, 32'h8000_0000);
        send_beat(CMD_OBSERVE, 32'hFFFF_FFFE);
        send_beat(CMD_OBSERVE, 32'hFFFF_FFFF);
        send_beat(CMD_UNUSED, 32'hA5A5_5A5A);
        send_beat(CMD_COLLECT, '0);
        send_beat(CMD_CLEAR, '0);
        send_beat(CMD_COLLECT, '0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            configure(ph);
            tx_burst = (ph % 3 == 0);
            rx_burst = (ph % 3 == 1);
            repeat (BEATS_PER_PHASE) random_beat();
        end
        drain();

        $display("Sent %0d command beats (%0d collects) over %0d bound settings.",
                 beats_sent, collects_sent, settings_used);
        $display("Compared %0d result lines, %0d mismatches.", lines_checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
